[rtl/core/ifgf_pkg.sv]
// ----------------------------------------------------------------------------
// ifgf_pkg: shared types and constants of the IMU frame glitch filter
// Frame layout, register map, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ifgf_pkg;

    // frame layout
    localparam int WORDS_PER_CH    = 12;
    localparam int FIRST_WORD_BYTE = 3;
    localparam int LAST_WORD_BYTE  = FIRST_WORD_BYTE + 2 * WORDS_PER_CH - 1;
    localparam int ANGLE_Y_WORD    = 10;
    localparam int WORD_IDX_W      = 4;

    // register map (index = paddr[3:2])
    localparam int          REG_IDX_W            = 2;
    localparam int          PADDR_W              = 4;
    localparam logic [1:0] REG_CHANNEL_COUNT    = 2'd0;
    localparam logic [1:0] REG_JUMP_LIMIT       = 2'd1;
    localparam logic [1:0] REG_ZERO_CROSS_LIMIT = 2'd2;
    localparam logic [1:0] REG_MAX_REJECTS      = 2'd3;

    localparam logic [3:0]  RST_CHANNEL_COUNT    = 4'd1;
    localparam logic [15:0] RST_JUMP_LIMIT       = 16'd910;
    localparam logic [15:0] RST_ZERO_CROSS_LIMIT = 16'd365;
    localparam logic [1:0]  RST_MAX_REJECTS      = 2'd2;

    localparam logic [1:0] GROUP_ANGLE = 2'd3;

    typedef struct packed {
        logic [3:0]  channel_count;
        logic [15:0] jump_limit;
        logic [15:0] zero_cross_limit;
        logic [1:0]  max_rejects;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_JUDGE_RD,
        S_JUDGE_EVAL,
        S_COPY_RD,
        S_COPY_WR,
        S_REP_A,
        S_REP_B,
        S_REP_C,
        S_REP_D,
        S_REP_OUT
    } state_t;

    typedef struct packed {
        logic capture;     // accepted byte
        logic walk_clear;  // zero channel, group and word counters
        logic judge_rd;    // read angle-y words of walk channel
        logic ch_next;     // next channel in judge pass
        logic first_clear;
        logic rej_clear;
        logic rej_inc;
        logic copy_wr;     // held word <= new word
        logic addr_inc;
        logic load_x;
        logic load_y;
        logic load_z;      // also loads channel, group, last flag
        logic rep_next;
    } cmd_t;

    typedef struct packed {
        logic poll_done;   // current byte ends the poll
        logic first_poll;
        logic glitch;      // unexcused glitch on walk channel
        logic rej_over;    // reject count would pass the limit
        logic walk_last;
        logic copy_last;
        logic rep_last;
    } sts_t;

endpackage

[rtl/core/ifgf_if.sv]
// ----------------------------------------------------------------------------
// ifgf_if: stream channels of the IMU frame glitch filter
// Byte channel in, report channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface ifgf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       poll_start;

    modport source (output valid, output rx_byte, output poll_start, input ready);
    modport sink   (input valid, input rx_byte, input poll_start, output ready);
endinterface

interface ifgf_report_if;
    logic               valid;
    logic               ready;
    logic [2:0]         sensor_channel;
    logic [1:0]         quantity_group;
    logic signed [15:0] value_x;
    logic signed [15:0] value_y;
    logic signed [15:0] value_z;
    logic               last_of_poll;

    modport source (output valid, output sensor_channel, output quantity_group,
                    output value_x, output value_y, output value_z,
                    output last_of_poll, input ready);
    modport sink   (input valid, input sensor_channel, input quantity_group,
                    input value_x, input value_y, input value_z,
                    input last_of_poll, output ready);
endinterface

[rtl/core/imu_frame_glitch_filter.sv]
// ----------------------------------------------------------------------------
// imu_frame_glitch_filter: angle-y glitch filter for polled IMU frames
//
// Usage:
//  - frame channel: one response byte per item with poll_start set on the
//    first byte of a poll. Each sensor channel sends FRAME_BYTES bytes;
//    bytes 3..26 hold twelve big-endian words (accel, gyro, mag, angle).
//  - report channel: after the last byte of a poll, 4 results per active
//    channel (channel 0 group 0 first), last_of_poll on the final one.
//  - APB port: channel_count, jump_limit, zero_cross_limit, max_rejects.
// Intake and walk:
//  - bytes are taken back to back while the block is idle.
//  - the last byte of a poll starts a walk that holds frame.ready low:
//    a judge (read, evaluate) per channel checked, a copy of an accepted
//    poll word by word (new store read, held store write), then the
//    results one at a time, each offered until the receiver takes it;
//    only then is the next byte taken.
// Reset clears positions and reject count and arms the first-poll accept;
// the word stores hold nothing meaningful until written.
// A stalled receiver holds the result steady and keeps intake closed.
// ----------------------------------------------------------------------------
module imu_frame_glitch_filter #(
    parameter int MAX_CHANNELS = 8,
    parameter int FRAME_BYTES  = 29
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ifgf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    ifgf_frame_if.sink                   frame,
    ifgf_report_if.source                report
);
    import ifgf_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // configuration registers
    ifgf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencing: byte intake, judge, copy, report
    ifgf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame.valid),
        .frame_ready  (frame.ready),
        .report_valid (report.valid),
        .report_ready (report.ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    // word stores, judge arithmetic and result registers
    ifgf_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .FRAME_BYTES  (FRAME_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .rx_byte        (frame.rx_byte),
        .poll_start     (frame.poll_start),
        .sensor_channel (report.sensor_channel),
        .quantity_group (report.quantity_group),
        .value_x        (report.value_x),
        .value_y        (report.value_y),
        .value_z        (report.value_z),
        .last_of_poll   (report.last_of_poll)
    );

endmodule

[rtl/core/ifgf_regs.sv]
// ----------------------------------------------------------------------------
// ifgf_regs: configuration registers
// APB-style write/read of channel count, jump limit, zero-cross limit and
// reject limit.
// ----------------------------------------------------------------------------
module ifgf_regs (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ifgf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output ifgf_pkg::cfg_t           cfg
);
    import ifgf_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[PADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_CHANNEL_COUNT:    cfg_next.channel_count    = pwdata[3:0];
                REG_JUMP_LIMIT:       cfg_next.jump_limit       = pwdata[15:0];
                REG_ZERO_CROSS_LIMIT: cfg_next.zero_cross_limit = pwdata[15:0];
                REG_MAX_REJECTS:      cfg_next.max_rejects      = pwdata[1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count    <= RST_CHANNEL_COUNT;
            cfg_reg.jump_limit       <= RST_JUMP_LIMIT;
            cfg_reg.zero_cross_limit <= RST_ZERO_CROSS_LIMIT;
            cfg_reg.max_rejects      <= RST_MAX_REJECTS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CHANNEL_COUNT:    prdata = {28'd0, cfg_reg.channel_count};
            REG_JUMP_LIMIT:       prdata = {16'd0, cfg_reg.jump_limit};
            REG_ZERO_CROSS_LIMIT: prdata = {16'd0, cfg_reg.zero_cross_limit};
            REG_MAX_REJECTS:      prdata = {30'd0, cfg_reg.max_rejects};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

[rtl/core/ifgf_dp.sv]
// ----------------------------------------------------------------------------
// ifgf_dp: datapath of the IMU frame glitch filter
// Frame position tracking, word capture into the new-value memory, angle-y
// judge, new-to-held copy and the report output registers.
// ----------------------------------------------------------------------------
module ifgf_dp #(
    parameter int MAX_CHANNELS = 8,
    parameter int FRAME_BYTES  = 29
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ifgf_pkg::cfg_t     cfg,
    input  ifgf_pkg::cmd_t     cmd,
    output ifgf_pkg::sts_t     sts,
    input  logic [7:0]         rx_byte,
    input  logic               poll_start,
    output logic [2:0]         sensor_channel,
    output logic [1:0]         quantity_group,
    output logic signed [15:0] value_x,
    output logic signed [15:0] value_y,
    output logic signed [15:0] value_z,
    output logic               last_of_poll
);
    import ifgf_pkg::*;

    localparam int MEM_DEPTH = MAX_CHANNELS * WORDS_PER_CH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NCH_W     = $clog2(MAX_CHANNELS + 1);
    localparam int POS_W     = $clog2(FRAME_BYTES);

    // word stores
    logic [15:0] new_mem  [MEM_DEPTH];
    logic [15:0] held_mem [MEM_DEPTH];
    logic [15:0] new_q_reg;
    logic [15:0] held_q_reg;
    logic [ADDR_W-1:0] new_rd_addr;
    logic [ADDR_W-1:0] held_rd_addr;

    // frame position
    logic [POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [CH_W-1:0]  ch_pos_reg, ch_pos_next;
    logic [7:0]       high_byte_reg, high_byte_next;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] off;
    logic [CH_W-1:0]  ch_eff;
    logic [NCH_W-1:0] nch;
    logic             in_words;
    logic             frame_end;
    logic             ch_last;
    logic             word_wr;
    logic [WORD_IDX_W-1:0] word_idx;
    logic [ADDR_W-1:0]     cap_addr;

    // walk state
    logic [CH_W-1:0]   walk_ch_reg, walk_ch_next;
    logic [1:0]        grp_reg, grp_next;
    logic [ADDR_W-1:0] lin_addr_reg, lin_addr_next;
    logic [1:0]        rej_reg, rej_next;
    logic              first_reg, first_next;
    logic [ADDR_W-1:0] judge_addr;
    logic [ADDR_W:0]   words_total;

    // judge arithmetic
    logic signed [15:0] o_val, n_val;
    logic [17:0] diff_s, sum_s;
    logic [16:0] abs_diff, abs_sum;
    logic        opposite, jump, excused;

    // report registers
    logic [2:0]  out_ch_reg;
    logic [1:0]  out_grp_reg;
    logic [15:0] x_reg, y_reg, z_reg;
    logic        out_last_reg;

    // active channel count, clamped to 1..MAX_CHANNELS
    always_comb
    begin
        if (cfg.channel_count == 4'd0)
            nch = NCH_W'(1);
        else if (cfg.channel_count > 4'(MAX_CHANNELS))
            nch = NCH_W'(MAX_CHANNELS);
        else
            nch = NCH_W'(cfg.channel_count);
    end

    // byte position and capture
    always_comb
    begin
        pos    = poll_start ? '0 : byte_pos_reg;
        ch_eff = (poll_start || (NCH_W'(ch_pos_reg) >= nch)) ? '0 : ch_pos_reg;
        in_words  = (pos >= POS_W'(FIRST_WORD_BYTE)) && (pos <= POS_W'(LAST_WORD_BYTE));
        off       = pos - POS_W'(FIRST_WORD_BYTE);
        word_idx  = WORD_IDX_W'(off >> 1);
        cap_addr  = ADDR_W'(ADDR_W'(ch_eff) * ADDR_W'(WORDS_PER_CH) + ADDR_W'(word_idx));
        word_wr   = cmd.capture && in_words && off[0];
        frame_end = (pos == POS_W'(FRAME_BYTES - 1));
        ch_last   = (NCH_W'(ch_eff) + NCH_W'(1)) >= nch;

        byte_pos_next  = byte_pos_reg;
        ch_pos_next    = ch_pos_reg;
        high_byte_next = high_byte_reg;
        if (cmd.capture)
        begin
            if (in_words && !off[0])
                high_byte_next = rx_byte;
            if (frame_end)
            begin
                byte_pos_next = '0;
                ch_pos_next   = ch_last ? '0 : CH_W'(NCH_W'(ch_eff) + NCH_W'(1));
            end
            else
            begin
                byte_pos_next = pos + POS_W'(1);
                ch_pos_next   = ch_eff;
            end
        end
    end

    // walk counters, reject count, first-poll flag
    always_comb
    begin
        walk_ch_next  = walk_ch_reg;
        grp_next      = grp_reg;
        lin_addr_next = lin_addr_reg;
        rej_next      = rej_reg;
        first_next    = first_reg;

        if (cmd.walk_clear)
        begin
            walk_ch_next  = '0;
            grp_next      = '0;
            lin_addr_next = '0;
        end
        if (cmd.ch_next)
            walk_ch_next = walk_ch_reg + CH_W'(1);
        if (cmd.addr_inc)
            lin_addr_next = lin_addr_reg + ADDR_W'(1);
        if (cmd.rep_next)
        begin
            grp_next = grp_reg + 2'd1;
            if (grp_reg == GROUP_ANGLE)
                walk_ch_next = walk_ch_reg + CH_W'(1);
        end
        if (cmd.first_clear)
            first_next = 1'b0;
        if (cmd.rej_clear)
            rej_next = '0;
        else if (cmd.rej_inc)
            rej_next = rej_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg  <= '0;
            ch_pos_reg    <= '0;
            high_byte_reg <= '0;
            walk_ch_reg   <= '0;
            grp_reg       <= '0;
            lin_addr_reg  <= '0;
            rej_reg       <= '0;
            first_reg     <= 1'b1;
        end
        else
        begin
            byte_pos_reg  <= byte_pos_next;
            ch_pos_reg    <= ch_pos_next;
            high_byte_reg <= high_byte_next;
            walk_ch_reg   <= walk_ch_next;
            grp_reg       <= grp_next;
            lin_addr_reg  <= lin_addr_next;
            rej_reg       <= rej_next;
            first_reg     <= first_next;
        end
    end

    // memories: one write and one registered read port each
    assign judge_addr = ADDR_W'(ADDR_W'(walk_ch_reg) * ADDR_W'(WORDS_PER_CH)
                                + ADDR_W'(ANGLE_Y_WORD));
    assign new_rd_addr  = cmd.judge_rd ? judge_addr : lin_addr_reg;
    assign held_rd_addr = cmd.judge_rd ? judge_addr : lin_addr_reg;

    always_ff @(posedge clk)
    begin
        if (word_wr)
            new_mem[cap_addr] <= {high_byte_reg, rx_byte};
        new_q_reg <= new_mem[new_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.copy_wr)
            held_mem[lin_addr_reg] <= new_q_reg;
        held_q_reg <= held_mem[held_rd_addr];
    end

    // angle-y judge on the registered read data
    always_comb
    begin
        o_val    = held_q_reg;
        n_val    = new_q_reg;
        diff_s   = {{2{o_val[15]}}, o_val} - {{2{n_val[15]}}, n_val};
        sum_s    = {{2{o_val[15]}}, o_val} + {{2{n_val[15]}}, n_val};
        abs_diff = diff_s[17] ? 17'(~diff_s + 18'd1) : diff_s[16:0];
        abs_sum  = sum_s[17]  ? 17'(~sum_s + 18'd1)  : sum_s[16:0];
        opposite = (o_val[15] && !n_val[15] && (n_val != 16'sd0))
                || (n_val[15] && !o_val[15] && (o_val != 16'sd0));
        jump     = abs_diff > {1'b0, cfg.jump_limit};
        excused  = opposite && (abs_sum < {1'b0, cfg.zero_cross_limit});
    end

    assign words_total = (ADDR_W + 1)'(nch) * (ADDR_W + 1)'(WORDS_PER_CH);

    always_comb
    begin
        sts.poll_done  = cmd.capture && frame_end && ch_last;
        sts.first_poll = first_reg;
        sts.glitch     = (opposite || jump) && !excused;
        sts.rej_over   = ({1'b0, rej_reg} + 3'd1) > {1'b0, cfg.max_rejects};
        sts.walk_last  = (NCH_W'(walk_ch_reg) + NCH_W'(1)) >= nch;
        sts.copy_last  = ({1'b0, lin_addr_reg} + (ADDR_W + 1)'(1)) == words_total;
        sts.rep_last   = sts.walk_last && (grp_reg == GROUP_ANGLE);
    end

    // report registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
            x_reg <= held_q_reg;
        if (cmd.load_y)
            y_reg <= held_q_reg;
        if (cmd.load_z)
        begin
            z_reg        <= held_q_reg;
            out_ch_reg   <= 3'(walk_ch_reg);
            out_grp_reg  <= grp_reg;
            out_last_reg <= sts.walk_last && (grp_reg == GROUP_ANGLE);
        end
    end

    assign sensor_channel = out_ch_reg;
    assign quantity_group = out_grp_reg;
    assign value_x        = x_reg;
    assign value_y        = y_reg;
    assign value_z        = z_reg;
    assign last_of_poll   = out_last_reg;

endmodule

[rtl/core/ifgf_ctrl.sv]
// ----------------------------------------------------------------------------
// ifgf_ctrl: controller of the IMU frame glitch filter
// Byte acceptance, then judge, copy and report passes at the end of a poll.
// ----------------------------------------------------------------------------
module ifgf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           frame_valid,
    output logic           frame_ready,
    output logic           report_valid,
    input  logic           report_ready,
    output ifgf_pkg::cmd_t cmd,
    input  ifgf_pkg::sts_t sts
);
    import ifgf_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        frame_ready  = 1'b0;
        report_valid = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                frame_ready = 1'b1;
                if (frame_valid)
                begin
                    cmd.capture = 1'b1;
                    if (sts.poll_done)
                    begin
                        cmd.walk_clear = 1'b1;
                        if (sts.first_poll)
                        begin
                            cmd.first_clear = 1'b1;
                            cmd.rej_clear   = 1'b1;
                            state_next      = S_COPY_RD;
                        end
                        else
                        begin
                            state_next = S_JUDGE_RD;
                        end
                    end
                end
            end
            S_JUDGE_RD:
            begin
                cmd.judge_rd = 1'b1;
                state_next   = S_JUDGE_EVAL;
            end
            S_JUDGE_EVAL:
            begin
                priority if (sts.glitch && sts.rej_over)
                begin
                    // forced acceptance
                    cmd.rej_clear  = 1'b1;
                    cmd.walk_clear = 1'b1;
                    state_next     = S_COPY_RD;
                end
                else if (sts.glitch)
                begin
                    cmd.rej_inc    = 1'b1;
                    cmd.walk_clear = 1'b1;
                    state_next     = S_REP_A;
                end
                else if (sts.walk_last)
                begin
                    cmd.rej_clear  = 1'b1;
                    cmd.walk_clear = 1'b1;
                    state_next     = S_COPY_RD;
                end
                else
                begin
                    cmd.ch_next = 1'b1;
                    state_next  = S_JUDGE_RD;
                end
            end
            S_COPY_RD:
            begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                cmd.copy_wr = 1'b1;
                if (sts.copy_last)
                begin
                    cmd.walk_clear = 1'b1;
                    state_next     = S_REP_A;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                    state_next   = S_COPY_RD;
                end
            end
            S_REP_A:
            begin
                cmd.addr_inc = 1'b1;
                state_next   = S_REP_B;
            end
            S_REP_B:
            begin
                cmd.addr_inc = 1'b1;
                cmd.load_x   = 1'b1;
                state_next   = S_REP_C;
            end
            S_REP_C:
            begin
                cmd.addr_inc = 1'b1;
                cmd.load_y   = 1'b1;
                state_next   = S_REP_D;
            end
            S_REP_D:
            begin
                cmd.load_z = 1'b1;
                state_next = S_REP_OUT;
            end
            S_REP_OUT:
            begin
                report_valid = 1'b1;
                if (report_ready)
                begin
                    if (sts.rep_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rep_next = 1'b1;
                        state_next   = S_REP_A;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // no byte taken while a result is on offer
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> !frame_ready)
        else $error("byte accepted during report");

    // last byte of a poll starts the end-of-poll walk
    a_poll_end: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_ready && sts.poll_done) |=> state_reg != S_IDLE)
        else $error("poll end did not start walk");

    // final result handed over returns to byte intake
    a_report_done: assert property (@(posedge clk) disable iff (!rst_n)
        (report_valid && report_ready && sts.rep_last) |=> state_reg == S_IDLE)
        else $error("report did not end after last result");

    // held store is only written during the copy pass
    a_copy_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_wr |-> (state_reg == S_COPY_WR) && !frame_ready)
        else $error("held write outside copy pass");

endmodule
